@@ hdl/a256x4_pkg.sv @@
// ----------------------------------------------------------------------------
// a256x4_pkg
// Shared types, request codes and AES round functions for the block core.
// ----------------------------------------------------------------------------
package a256x4_pkg;

  localparam int LANE_COUNT_DEF = 4;
  localparam int LANE_MAX       = 4;
  localparam int NUM_BLK        = 6;
  localparam int BLK_W          = 512;
  localparam int LANE_W         = 128;

  localparam logic [2:0] REQ_LOAD    = 3'd0;
  localparam logic [2:0] REQ_ABSORB  = 3'd1;
  localparam logic [2:0] REQ_ENCRYPT = 3'd2;
  localparam logic [2:0] REQ_DECRYPT = 3'd3;
  localparam logic [2:0] REQ_READ    = 3'd4;

  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [LANE_W-1:0] lane_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a lane sits at bits [8i+7:8i]
  function automatic lane_t aes_round(input lane_t s, input lane_t k);
    logic [7:0] t [16];
    lane_t      o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = sbox(s[8*(r + 4*((c + r) % 4)) +: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      o[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3 ^ k[8*(4*c) +: 8];
      o[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3 ^ k[8*(4*c+1) +: 8];
      o[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3 ^ k[8*(4*c+2) +: 8];
      o[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3) ^ k[8*(4*c+3) +: 8];
    end
    return o;
  endfunction

endpackage

@@ hdl/a256x4_lane.sv @@
// ----------------------------------------------------------------------------
// a256x4_lane
// One 128-bit lane: keystream output and six-way AES round state update.
// ----------------------------------------------------------------------------
module a256x4_lane (
  input  logic [2:0]             req_type,
  input  a256x4_pkg::lane_t      msg,
  input  a256x4_pkg::lane_t      s0,
  input  a256x4_pkg::lane_t      s1,
  input  a256x4_pkg::lane_t      s2,
  input  a256x4_pkg::lane_t      s3,
  input  a256x4_pkg::lane_t      s4,
  input  a256x4_pkg::lane_t      s5,
  output a256x4_pkg::lane_t      ks_out,
  output a256x4_pkg::lane_t      n0,
  output a256x4_pkg::lane_t      n1,
  output a256x4_pkg::lane_t      n2,
  output a256x4_pkg::lane_t      n3,
  output a256x4_pkg::lane_t      n4,
  output a256x4_pkg::lane_t      n5
);
  import a256x4_pkg::*;

  lane_t ct;
  lane_t d;

  assign ct     = msg ^ s5 ^ s4 ^ s1 ^ (s2 & s3);
  assign ks_out = ct;
  assign d      = (req_type == REQ_DECRYPT) ? ct : msg;
  assign n0     = aes_round(s5, s0) ^ d;
  assign n1     = aes_round(s0, s1);
  assign n2     = aes_round(s1, s2);
  assign n3     = aes_round(s2, s3);
  assign n4     = aes_round(s3, s4);
  assign n5     = aes_round(s4, s5);

endmodule

@@ hdl/aegis256x4_block_core.sv @@
// ----------------------------------------------------------------------------
// aegis256x4_block_core
// Six 512-bit state blocks of four AES lanes, with load, read, absorb,
// encrypt and decrypt requests.
// ----------------------------------------------------------------------------
// Input stream s_axis: one transfer is one request; s_axis_tuser carries the
// request type and block index, s_axis_tdata the 64-byte block.
// Output stream m_axis: one transfer per request, 64-byte result in
// m_axis_tdata and the status bit in m_axis_tuser.
// The lanes run one AES round on all six state blocks at once and the
// result lands in the output register at the accepting edge; the block
// takes one request per cycle while the output register can drain.
// The state is updated at the accepting edge, so the next request sees it.
// When the receiver stalls, the output register holds its result and the
// input is ready only if that register drains in the same cycle.
// Reset clears all state blocks and empties the output register.
// ----------------------------------------------------------------------------
module aegis256x4_block_core #(
  parameter int LANE_COUNT = a256x4_pkg::LANE_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [511:0] s_axis_tdata,   // data0 .. data7
  input  logic [5:0]   s_axis_tuser,   // req_type[2:0], block_index[5:3]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [511:0] m_axis_tdata,   // out0 .. out7
  output logic         m_axis_tuser    // status
);
  import a256x4_pkg::*;

  localparam int LANES = (LANE_COUNT > LANE_MAX) ? LANE_MAX : LANE_COUNT;

  blk_t       st [NUM_BLK];
  blk_t       st_next [NUM_BLK];
  blk_t       upd [NUM_BLK];
  blk_t       ks;
  blk_t       res_next;
  logic       stat_next;
  logic [2:0] req_type;
  logic [2:0] block_index;
  logic       accept;
  logic       idx_ok;

  assign req_type    = s_axis_tuser[2:0];
  assign block_index = s_axis_tuser[5:3];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign idx_ok      = block_index < 3'(NUM_BLK);

  genvar l;
  generate
    for (l = 0; l < LANE_MAX; l++) begin : g_lane
      if (l < LANES) begin : g_on
        a256x4_lane u_lane (
          .req_type (req_type),
          .msg      (s_axis_tdata[LANE_W*l +: LANE_W]),
          .s0       (st[0][LANE_W*l +: LANE_W]),
          .s1       (st[1][LANE_W*l +: LANE_W]),
          .s2       (st[2][LANE_W*l +: LANE_W]),
          .s3       (st[3][LANE_W*l +: LANE_W]),
          .s4       (st[4][LANE_W*l +: LANE_W]),
          .s5       (st[5][LANE_W*l +: LANE_W]),
          .ks_out   (ks[LANE_W*l +: LANE_W]),
          .n0       (upd[0][LANE_W*l +: LANE_W]),
          .n1       (upd[1][LANE_W*l +: LANE_W]),
          .n2       (upd[2][LANE_W*l +: LANE_W]),
          .n3       (upd[3][LANE_W*l +: LANE_W]),
          .n4       (upd[4][LANE_W*l +: LANE_W]),
          .n5       (upd[5][LANE_W*l +: LANE_W])
        );
      end else begin : g_off
        assign ks[LANE_W*l +: LANE_W] = '0;
        for (genvar b = 0; b < NUM_BLK; b++) begin : g_hold
          assign upd[b][LANE_W*l +: LANE_W] = st[b][LANE_W*l +: LANE_W];
        end
      end
    end
  endgenerate

  // merge lane results into state and output
  always_comb begin
    for (int b = 0; b < NUM_BLK; b++) begin
      st_next[b] = st[b];
    end
    res_next  = '0;
    stat_next = 1'b0;
    unique case (req_type)
      REQ_LOAD: begin
        if (idx_ok) st_next[block_index] = s_axis_tdata;
        else stat_next = 1'b1;
      end
      REQ_READ: begin
        if (idx_ok) res_next = st[block_index];
        else stat_next = 1'b1;
      end
      REQ_ABSORB: begin
        for (int b = 0; b < NUM_BLK; b++) st_next[b] = upd[b];
      end
      REQ_ENCRYPT, REQ_DECRYPT: begin
        for (int b = 0; b < NUM_BLK; b++) st_next[b] = upd[b];
        res_next = ks;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BLK; b++) st[b] <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        for (int b = 0; b < NUM_BLK; b++) st[b] <= st_next[b];
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= res_next;
      m_axis_tuser <= stat_next;
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the AEGIS-256X4 block core. Requests are driven on
// the input stream with random gaps; each result is compared, field by field,
// with a prediction computed from a private copy of the six state blocks.
// ----------------------------------------------------------------------------
module testbench;
  import a256x4_pkg::*;

  localparam int LANES     = LANE_COUNT_DEF;
  localparam int WDOG_MAX  = 20000;

  typedef struct packed {
    logic         status;
    logic [511:0] blk;
  } result_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [511:0] s_axis_tdata;
  logic [5:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [511:0] m_axis_tdata;
  logic         m_axis_tuser;

  blk_t    cipher_blk [NUM_BLK];
  result_t expected_results [$];
  int      error_count;
  int      idle_cycles;
  bit      stall_enable;

  aegis256x4_block_core #(.LANE_COUNT(LANES)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Independent AES round: SubBytes, ShiftRows, MixColumns, then key add.
  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return x[7] ? ((x << 1) ^ 8'h1b) : (x << 1);
  endfunction

  function automatic lane_t round_lane(input lane_t s, input lane_t k);
    lane_t      o;
    logic [7:0] col [4];
    logic [7:0] all;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        col[r] = sbox(s[8*(r + 4*((c + r) & 3)) +: 8]);
      end
      all = col[0] ^ col[1] ^ col[2] ^ col[3];
      for (int r = 0; r < 4; r++) begin
        o[8*(4*c + r) +: 8] = all ^ col[r] ^ gf_dbl(col[r] ^ col[(r + 1) & 3])
                              ^ k[8*(4*c + r) +: 8];
      end
    end
    return o;
  endfunction

  function automatic result_t predict_request(input logic [2:0] req,
                                              input logic [2:0] idx,
                                              input logic [511:0] din);
    result_t r;
    blk_t    nxt [NUM_BLK];
    blk_t    feed;
    r = '0;
    case (req)
      REQ_LOAD, REQ_READ: begin
        if (idx >= NUM_BLK) begin
          r.status = 1'b1;
        end else if (req == REQ_LOAD) begin
          cipher_blk[idx] = din;
        end else begin
          r.blk = cipher_blk[idx];
        end
      end
      REQ_ABSORB, REQ_ENCRYPT, REQ_DECRYPT: begin
        if (req != REQ_ABSORB) begin
          for (int l = 0; l < LANES; l++) begin
            r.blk[128*l +: 128] = din[128*l +: 128] ^ cipher_blk[5][128*l +: 128]
              ^ cipher_blk[4][128*l +: 128] ^ cipher_blk[1][128*l +: 128]
              ^ (cipher_blk[2][128*l +: 128] & cipher_blk[3][128*l +: 128]);
          end
        end
        feed = (req == REQ_DECRYPT) ? r.blk : din;
        nxt = cipher_blk;
        for (int l = 0; l < LANES; l++) begin
          nxt[0][128*l +: 128] = round_lane(cipher_blk[5][128*l +: 128],
                                            cipher_blk[0][128*l +: 128])
                                 ^ feed[128*l +: 128];
          for (int b = 1; b < NUM_BLK; b++) begin
            nxt[b][128*l +: 128] = round_lane(cipher_blk[b-1][128*l +: 128],
                                              cipher_blk[b][128*l +: 128]);
          end
        end
        cipher_blk = nxt;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [511:0] rand_block();
    logic [511:0] v;
    for (int i = 0; i < 16; i++) v[32*i +: 32] = $urandom;
    return v;
  endfunction

  // hold tvalid across back-to-back transfers; drop it only for a gap
  task automatic send_request(input logic [2:0] req, input logic [2:0] idx,
                              input logic [511:0] din);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {idx, req};
    s_axis_tdata  <= din;
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(predict_request(req, idx, din));
    @(negedge clk);
  endtask

  // drop tvalid and drain the output until no result is outstanding
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [511:0] ones;
    ones = '1;
    for (int b = 0; b < 8; b++) send_request(REQ_READ, b[2:0], '0);
    send_request(REQ_ENCRYPT, 3'd7, '0);
    send_request(REQ_LOAD, 3'd0, ones);
    send_request(REQ_LOAD, 3'd5, rand_block());
    send_request(REQ_LOAD, 3'd6, ones);
    send_request(REQ_LOAD, 3'd7, ones);
    send_request(REQ_ABSORB, 3'd6, ones);
    send_request(REQ_ENCRYPT, 3'd0, ones);
    send_request(REQ_DECRYPT, 3'd7, rand_block());
    for (int t = 5; t < 8; t++) send_request(t[2:0], 3'd0, ones);
    send_request(REQ_READ, 3'd0, '0);
    send_request(REQ_READ, 3'd5, ones);
    wait_drained();
  endtask

  task automatic test_random_sessions();
    int p;
    logic [2:0] req;
    for (int n = 0; n < 1300; n++) begin
      p = $urandom_range(0, 99);
      if (p < 12) req = REQ_LOAD;
      else if (p < 30) req = REQ_ABSORB;
      else if (p < 55) req = REQ_ENCRYPT;
      else if (p < 80) req = REQ_DECRYPT;
      else if (p < 95) req = REQ_READ;
      else req = 3'($urandom_range(5, 7));
      send_request(req, 3'($urandom_range(0, 7)), rand_block());
    end
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (rst || !stall_enable) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < 70);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: %h", got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        for (int j = 0; j < 8; j++) begin
          if (got.blk[64*j +: 64] !== want.blk[64*j +: 64]) begin
            $error("out%0d: expected %h, actual %h", j, want.blk[64*j +: 64],
                   got.blk[64*j +: 64]);
            error_count++;
          end
        end
        if (got.status !== want.status) begin
          $error("status: expected %b, actual %b", want.status, got.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (!s_axis_tvalid && expected_results.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b1;
    error_count   = 0;
    idle_cycles   = 0;
    stall_enable  = 1'b0;
    for (int b = 0; b < NUM_BLK; b++) cipher_blk[b] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    stall_enable = 1'b1;
    test_random_sessions();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
